// File: sv/cfa_pkg.sv
// Shared constants, register indexes and the CORDIC arctangent table for the attitude filter.
package cfa_pkg;

  localparam int CORDIC_ITERATIONS_DEF = 16;
  localparam int ANGLE_FRAC_BITS_DEF = 7;
  localparam int ATAN_TABLE_LEN = 24;

  // Gyro scale times milliseconds per second
  localparam int RATE_TIMES_MS = 131000;
  localparam int DT_CAP_MS = 1000;

  // Configuration register indexes
  localparam logic [2:0] REG_ACCEL_BIAS_X = 3'd0;
  localparam logic [2:0] REG_ACCEL_BIAS_Y = 3'd1;
  localparam logic [2:0] REG_ACCEL_BIAS_Z = 3'd2;
  localparam logic [2:0] REG_GYRO_BIAS_X = 3'd3;
  localparam logic [2:0] REG_GYRO_BIAS_Y = 3'd4;
  localparam logic [2:0] REG_GYRO_BIAS_Z = 3'd5;
  localparam logic [2:0] REG_BLEND_WEIGHT = 3'd6;

  localparam logic [15:0] BLEND_WEIGHT_RST = 16'd64225;

  // atan(2^-i) in degrees, Q16, rounded
  function automatic logic [21:0] atan_q16(input logic [4:0] idx);
    logic [21:0] v;
    unique case (idx)
      5'd0:  v = 22'd2949120;
      5'd1:  v = 22'd1740967;
      5'd2:  v = 22'd919879;
      5'd3:  v = 22'd466945;
      5'd4:  v = 22'd234379;
      5'd5:  v = 22'd117304;
      5'd6:  v = 22'd58666;
      5'd7:  v = 22'd29335;
      5'd8:  v = 22'd14668;
      5'd9:  v = 22'd7334;
      5'd10: v = 22'd3667;
      5'd11: v = 22'd1833;
      5'd12: v = 22'd917;
      5'd13: v = 22'd458;
      5'd14: v = 22'd229;
      5'd15: v = 22'd115;
      5'd16: v = 22'd57;
      5'd17: v = 22'd29;
      5'd18: v = 22'd14;
      5'd19: v = 22'd7;
      5'd20: v = 22'd4;
      5'd21: v = 22'd2;
      5'd22: v = 22'd1;
      default: v = 22'd0;
    endcase
    return v;
  endfunction

endpackage

// File: sv/complementary_filter_attitude.sv
// Complementary-filter attitude estimator: one sample in, pitch, roll and yaw out.
// in_ready is high only in the idle state between items. The time goes to one shared
// multiplier, a bit-serial square root (16 steps plus a load step), one CORDIC vectoring
// datapath run twice (CORDIC_ITERATIONS steps plus a load step each), six blend steps
// per tilt angle and two for yaw, and a rounded division by a constant done as a
// reciprocal multiply with one correction step. A finished result sits in the output
// register while the next item is already being accepted and worked on; an item only
// waits in the output step when the previous result is still not taken.
module complementary_filter_attitude #(
  parameter int CORDIC_ITERATIONS = cfa_pkg::CORDIC_ITERATIONS_DEF,
  parameter int ANGLE_FRAC_BITS = cfa_pkg::ANGLE_FRAC_BITS_DEF
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               cfg_we,
  input  logic [2:0]         cfg_addr,
  input  logic [15:0]        cfg_data,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic signed [15:0] accel_x,
  input  logic signed [15:0] accel_y,
  input  logic signed [15:0] accel_z,
  input  logic signed [15:0] gyro_x,
  input  logic signed [15:0] gyro_y,
  input  logic signed [15:0] gyro_z,
  input  logic [31:0]        tick_ms,
  output logic               out_valid,
  input  logic               out_ready,
  output logic signed [15:0] pitch_out,
  output logic signed [15:0] roll_out,
  output logic [15:0]        yaw_out
);

  localparam int F = ANGLE_FRAC_BITS;
  localparam int AW = F + 10;          // angle state, signed
  localparam int DW = F + 28;          // blend intermediates, signed
  localparam int PW = DW + 18;         // multiplier product
  localparam int NW = F + 45;          // blend numerator, signed
  localparam int UW = F + 45;          // divider magnitude
  localparam int QB = F + 12;          // quotient bits
  localparam int CW = 27;              // CORDIC x/y
  localparam int ZW = 26;              // CORDIC angle, Q16 degrees
  localparam int SQ_STEPS = 16;
  localparam int MAXI = (CORDIC_ITERATIONS > SQ_STEPS) ? CORDIC_ITERATIONS : SQ_STEPS;
  localparam int CNT_W = $clog2(MAXI + 1);

  localparam logic [UW-1:0] DIV_BIG = UW'(64'd65536 * 64'd131000);
  localparam logic [UW-1:0] DIV_SMALL = UW'(cfa_pkg::RATE_TIMES_MS);
  localparam logic signed [17:0] RATE_K = 18'(cfa_pkg::RATE_TIMES_MS);
  // Both divisors are a power of two times this odd factor
  localparam int DIV_ODD = cfa_pkg::RATE_TIMES_MS / 8;
  localparam int SH_BIG = 19;
  localparam int SH_SMALL = 3;
  localparam int RECIP_SH = 30;
  localparam logic signed [17:0] DIV_RECIP = 18'((64'd1 << RECIP_SH) / DIV_ODD);
  localparam logic signed [17:0] DIV_ODD_K = 18'(DIV_ODD);
  localparam int LIM_I = 180 << F;
  localparam int FULL_I = 360 << F;
  localparam logic signed [QB:0] LIM_POS = (QB+1)'(LIM_I);
  localparam logic signed [QB:0] LIM_NEG = -((QB+1)'(LIM_I));
  localparam logic signed [QB:0] FULL_ANG = (QB+1)'(FULL_I);
  localparam logic signed [ZW-1:0] Z_HALF = ZW'(1 << (15 - F));
  localparam logic signed [ZW-1:0] Z_90 = ZW'(90 * 65536);

  // Sequencer codes
  localparam logic [4:0] ST_IDLE = 5'd0;
  localparam logic [4:0] ST_SQ0  = 5'd1;
  localparam logic [4:0] ST_SQ1  = 5'd2;
  localparam logic [4:0] ST_SQ2  = 5'd3;
  localparam logic [4:0] ST_SQRT = 5'd4;
  localparam logic [4:0] ST_CORD = 5'd5;
  localparam logic [4:0] ST_B0   = 5'd6;
  localparam logic [4:0] ST_B1   = 5'd7;
  localparam logic [4:0] ST_B2   = 5'd8;
  localparam logic [4:0] ST_B3   = 5'd9;
  localparam logic [4:0] ST_B4   = 5'd10;
  localparam logic [4:0] ST_B5   = 5'd11;
  localparam logic [4:0] ST_Y0   = 5'd12;
  localparam logic [4:0] ST_Y1   = 5'd13;
  localparam logic [4:0] ST_DV0  = 5'd14;
  localparam logic [4:0] ST_DV1  = 5'd15;
  localparam logic [4:0] ST_DV2  = 5'd16;
  localparam logic [4:0] ST_DV3  = 5'd17;
  localparam logic [4:0] ST_FIN  = 5'd18;
  localparam logic [4:0] ST_OUT  = 5'd19;

  localparam logic [1:0] SEL_PITCH = 2'd0;
  localparam logic [1:0] SEL_ROLL  = 2'd1;
  localparam logic [1:0] SEL_YAW   = 2'd2;

  // Configuration
  logic signed [15:0] accel_bias_x, accel_bias_y, accel_bias_z;
  logic signed [15:0] gyro_bias_x, gyro_bias_y, gyro_bias_z;
  logic [15:0]        blend_weight;

  // Filter state
  logic signed [AW-1:0] pitch_angle, roll_angle, yaw_angle;
  logic [31:0]          last_tick;

  // Sample registers
  logic signed [15:0] ax, ay, az, gx, gy, gz;
  logic [9:0]         dt;
  logic [31:0]        dt_raw;

  logic [4:0]        state;
  logic [1:0]        sel;
  logic [CNT_W-1:0]  cnt;

  // Shared multiplier
  logic signed [DW-1:0] mul_a;
  logic signed [17:0]   mul_b;
  logic signed [PW-1:0] p;

  // Square root
  logic [31:0] sqv, sq_res, sq_bit, sq_sum;
  logic [16:0] mag;

  // CORDIC
  logic signed [CW-1:0] cx, cy, xs, ys;
  logic signed [ZW-1:0] cz, atan_v, z_round;
  logic                 czero;
  logic signed [16:0]   ld_y, ld_x;
  logic signed [CW-1:0] ld_cx, ld_cy, x256, y256;
  logic signed [ZW-1:0] ld_cz;
  logic signed [AW-1:0] cord_ang, acc_p, acc_r;

  // Blend
  logic signed [DW-1:0] dreg, treg;
  logic signed [AW-1:0] ang_sel, acc_sel;
  logic signed [15:0]   rate_sel;

  // Divider
  logic signed [NW-1:0] div_num;
  logic [UW-1:0]        div_mag, div_half, div_d, div_sum, div_scaled;
  logic [UW-1:0]        drem, div_left;
  logic [QB-1:0]        dq;
  logic                 dneg;
  logic signed [QB:0]   q_s, r_s, r_sat, y_s;

  logic signed [31:0] pitch_ext, roll_ext, yaw_ext;

  assign in_ready = (state == ST_IDLE);
  assign dt_raw = tick_ms - last_tick;

  // Per-angle operand selection
  always_comb begin
    ang_sel = (sel == SEL_ROLL) ? roll_angle : pitch_angle;
    acc_sel = (sel == SEL_ROLL) ? acc_r : acc_p;
    rate_sel = (sel == SEL_ROLL) ? gy : gx;
  end

  // Multiplier operands by step
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    case (state)
      ST_SQ0: begin mul_a = DW'(ay); mul_b = 18'(ay); end
      ST_SQ1: begin mul_a = DW'(az); mul_b = 18'(az); end
      ST_B0:  begin mul_a = DW'(rate_sel); mul_b = {8'd0, dt}; end
      ST_B1:  begin mul_a = DW'(ang_sel); mul_b = RATE_K; end
      ST_B2:  begin mul_a = DW'(acc_sel); mul_b = RATE_K; end
      ST_B4:  begin mul_a = dreg; mul_b = {2'b00, blend_weight}; end
      ST_Y0:  begin mul_a = DW'(gz); mul_b = {8'd0, dt}; end
      ST_DV0: begin mul_a = $signed(drem[DW-1:0]); mul_b = DIV_RECIP; end
      ST_DV2: begin mul_a = DW'(dq); mul_b = DIV_ODD_K; end
      default: begin mul_a = '0; mul_b = '0; end
    endcase
  end

  // Square root step
  assign sq_sum = sq_res + sq_bit;

  // CORDIC operand load with quadrant pre-rotation
  always_comb begin
    if (state == ST_SQRT) begin
      ld_y = 17'(ay);
      ld_x = 17'(az);
    end else begin
      ld_y = -(17'(ax));
      ld_x = $signed(mag);
    end
    x256 = CW'(ld_x) <<< 8;
    y256 = CW'(ld_y) <<< 8;
    if (x256 < 0) begin
      if (y256 >= 0) begin
        ld_cx = y256; ld_cy = -x256; ld_cz = Z_90;
      end else begin
        ld_cx = -y256; ld_cy = x256; ld_cz = -Z_90;
      end
    end else begin
      ld_cx = x256; ld_cy = y256; ld_cz = '0;
    end
  end

  // CORDIC micro-rotation and final conversion
  always_comb begin
    xs = cx >>> cnt;
    ys = cy >>> cnt;
    atan_v = ZW'(cfa_pkg::atan_q16(5'(cnt)));
    z_round = (cz + Z_HALF) >>> (16 - F);
    cord_ang = czero ? '0 : z_round[AW-1:0];
  end

  // Divider operands: magnitude plus half divisor, power-of-two part shifted out
  always_comb begin
    if (state == ST_B5) begin
      div_num = p[NW-1:0] + ({{(NW-DW){treg[DW-1]}}, treg} <<< 16);
      div_d = DIV_BIG;
    end else begin
      div_num = p[NW-1:0] <<< F;
      div_d = DIV_SMALL;
    end
    div_half = div_d >> 1;
    div_mag = (div_num < 0) ? UW'(-div_num) : UW'(div_num);
    div_sum = div_mag + div_half;
    div_scaled = (state == ST_B5) ? (div_sum >> SH_BIG) : (div_sum >> SH_SMALL);
    // Remainder left after the estimated quotient
    div_left = drem - UW'(p[DW-1:0]);
  end

  // Signed quotient, saturation and yaw wrap
  always_comb begin
    q_s = $signed({1'b0, dq});
    r_s = dneg ? -q_s : q_s;
    if (r_s > LIM_POS) r_sat = LIM_POS;
    else if (r_s < LIM_NEG) r_sat = LIM_NEG;
    else r_sat = r_s;
    y_s = (QB+1)'(yaw_angle) + r_s;
    if (y_s >= FULL_ANG) y_s = y_s - FULL_ANG;
    else if (y_s < 0) y_s = y_s + FULL_ANG;
  end

  // Configuration writes
  always_ff @(posedge clk) begin
    if (rst) begin
      accel_bias_x <= '0;
      accel_bias_y <= '0;
      accel_bias_z <= '0;
      gyro_bias_x <= '0;
      gyro_bias_y <= '0;
      gyro_bias_z <= '0;
      blend_weight <= cfa_pkg::BLEND_WEIGHT_RST;
    end else if (cfg_we) begin
      unique case (cfg_addr)
        cfa_pkg::REG_ACCEL_BIAS_X: accel_bias_x <= cfg_data;
        cfa_pkg::REG_ACCEL_BIAS_Y: accel_bias_y <= cfg_data;
        cfa_pkg::REG_ACCEL_BIAS_Z: accel_bias_z <= cfg_data;
        cfa_pkg::REG_GYRO_BIAS_X:  gyro_bias_x <= cfg_data;
        cfa_pkg::REG_GYRO_BIAS_Y:  gyro_bias_y <= cfg_data;
        cfa_pkg::REG_GYRO_BIAS_Z:  gyro_bias_z <= cfg_data;
        cfa_pkg::REG_BLEND_WEIGHT: blend_weight <= cfg_data;
        default: ;
      endcase
    end
  end

  // Datapath registers without reset
  always_ff @(posedge clk) begin
    p <= mul_a * mul_b;
    if (state == ST_IDLE && in_valid) begin
      ax <= accel_x - accel_bias_x;
      ay <= accel_y - accel_bias_y;
      az <= accel_z - accel_bias_z;
      gx <= gyro_x - gyro_bias_x;
      gy <= gyro_y - gyro_bias_y;
      gz <= gyro_z - gyro_bias_z;
      dt <= (dt_raw > 32'(cfa_pkg::DT_CAP_MS)) ? 10'(cfa_pkg::DT_CAP_MS) : dt_raw[9:0];
    end
  end

  // Sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      sel <= SEL_PITCH;
      cnt <= '0;
      out_valid <= 1'b0;
      pitch_angle <= '0;
      roll_angle <= '0;
      yaw_angle <= '0;
      last_tick <= '0;
    end else begin
      if (out_valid && out_ready && state != ST_OUT) out_valid <= 1'b0;
      unique case (state)
        ST_IDLE: begin
          if (in_valid) begin
            last_tick <= tick_ms;
            state <= ST_SQ0;
          end
        end
        ST_SQ0: state <= ST_SQ1;
        ST_SQ1: begin
          sqv <= p[31:0];
          state <= ST_SQ2;
        end
        ST_SQ2: begin
          sqv <= sqv + p[31:0];
          sq_res <= '0;
          sq_bit <= 32'h4000_0000;
          cnt <= '0;
          state <= ST_SQRT;
        end
        ST_SQRT: begin
          if (cnt == CNT_W'(SQ_STEPS)) begin
            mag <= sq_res[16:0];
            cx <= ld_cx;
            cy <= ld_cy;
            cz <= ld_cz;
            czero <= (ld_x == 0) && (ld_y == 0);
            sel <= SEL_PITCH;
            cnt <= '0;
            state <= ST_CORD;
          end else begin
            if (sqv >= sq_sum) begin
              sqv <= sqv - sq_sum;
              sq_res <= (sq_res >> 1) + sq_bit;
            end else begin
              sq_res <= sq_res >> 1;
            end
            sq_bit <= sq_bit >> 2;
            cnt <= cnt + 1'b1;
          end
        end
        ST_CORD: begin
          if (cnt == CNT_W'(CORDIC_ITERATIONS)) begin
            cnt <= '0;
            if (sel == SEL_PITCH) begin
              acc_p <= cord_ang;
              cx <= ld_cx;
              cy <= ld_cy;
              cz <= ld_cz;
              czero <= (ld_x == 0) && (ld_y == 0);
              sel <= SEL_ROLL;
            end else begin
              acc_r <= cord_ang;
              sel <= SEL_PITCH;
              state <= ST_B0;
            end
          end else begin
            if (!cy[CW-1]) begin
              cx <= cx + ys;
              cy <= cy - xs;
              cz <= cz + atan_v;
            end else begin
              cx <= cx - ys;
              cy <= cy + xs;
              cz <= cz - atan_v;
            end
            cnt <= cnt + 1'b1;
          end
        end
        ST_B0: state <= ST_B1;
        ST_B1: begin
          dreg <= p[DW-1:0] <<< F;
          state <= ST_B2;
        end
        ST_B2: begin
          dreg <= dreg + p[DW-1:0];
          state <= ST_B3;
        end
        ST_B3: begin
          dreg <= dreg - p[DW-1:0];
          treg <= p[DW-1:0];
          state <= ST_B4;
        end
        ST_B4: state <= ST_B5;
        ST_B5, ST_Y1: begin
          drem <= div_scaled;
          dneg <= (div_num < 0);
          state <= ST_DV0;
        end
        ST_Y0: state <= ST_Y1;
        ST_DV0: state <= ST_DV1;
        // Reciprocal estimate, never above the true quotient and at most one below
        ST_DV1: begin
          dq <= p[RECIP_SH +: QB];
          state <= ST_DV2;
        end
        ST_DV2: state <= ST_DV3;
        ST_DV3: begin
          if (div_left >= UW'(DIV_ODD)) dq <= dq + 1'b1;
          state <= ST_FIN;
        end
        ST_FIN: begin
          unique case (sel)
            SEL_PITCH: begin
              pitch_angle <= r_sat[AW-1:0];
              sel <= SEL_ROLL;
              state <= ST_B0;
            end
            SEL_ROLL: begin
              roll_angle <= r_sat[AW-1:0];
              sel <= SEL_YAW;
              state <= ST_Y0;
            end
            default: begin
              yaw_angle <= y_s[AW-1:0];
              sel <= SEL_PITCH;
              state <= ST_OUT;
            end
          endcase
        end
        ST_OUT: begin
          if (!out_valid || out_ready) begin
            pitch_out <= pitch_ext[15:0];
            roll_out <= roll_ext[15:0];
            yaw_out <= yaw_ext[15:0];
            out_valid <= 1'b1;
            state <= ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  assign pitch_ext = 32'(pitch_angle);
  assign roll_ext = 32'(roll_angle);
  assign yaw_ext = 32'(yaw_angle);

endmodule

// File: sv/cfa_checker.sv
// Port-level checks for the attitude filter, bound to the top level.
module cfa_checker #(
  parameter int ANGLE_FRAC_BITS = cfa_pkg::ANGLE_FRAC_BITS_DEF
) (
  input logic               clk,
  input logic               rst,
  input logic               in_valid,
  input logic               in_ready,
  input logic               out_valid,
  input logic               out_ready,
  input logic signed [15:0] pitch_out,
  input logic signed [15:0] roll_out,
  input logic [15:0]        yaw_out
);

  localparam bit NARROW = (ANGLE_FRAC_BITS <= 7);
  localparam logic signed [16:0] LIM = 17'(180 << ANGLE_FRAC_BITS);
  localparam logic [16:0] FULL = 17'(360 << ANGLE_FRAC_BITS);

  // The block works on one item at a time
  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |=> !in_ready)
    else $error("in_ready stayed high after an item was accepted");

  // A result waiting for the consumer holds its pitch and yaw
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(pitch_out) && $stable(yaw_out))
    else $error("pending result changed");

  // Angles stay in range
  a_tilt_range: assert property (@(posedge clk) disable iff (rst)
    NARROW && out_valid |-> 17'(pitch_out) <= LIM && 17'(pitch_out) >= -LIM
      && 17'(roll_out) <= LIM && 17'(roll_out) >= -LIM)
    else $error("pitch or roll beyond 180 degrees");

  a_yaw_range: assert property (@(posedge clk) disable iff (rst)
    NARROW && out_valid |-> {1'b0, yaw_out} < FULL)
    else $error("yaw not wrapped below 360 degrees");

  // Reset clears out_valid
  a_reset: assert property (@(posedge clk) rst |=> !out_valid)
    else $error("out_valid high after reset");

endmodule

bind complementary_filter_attitude cfa_checker #(.ANGLE_FRAC_BITS(ANGLE_FRAC_BITS)) u_cfa_checker (
  .clk(clk), .rst(rst), .in_valid(in_valid), .in_ready(in_ready),
  .out_valid(out_valid), .out_ready(out_ready),
  .pitch_out(pitch_out), .roll_out(roll_out), .yaw_out(yaw_out)
);
